// ----- design/stt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // Series length limit and the counters that follow from it.
    localparam int MAX_TERMS = 16;
    localparam int TERMS_W   = $clog2(MAX_TERMS + 1);
    localparam int TERMS_CAP = (MAX_TERMS > 31) ? 31 : MAX_TERMS;
    localparam int TERMS_OUT_W = 5;

    // Largest divisor n*(n-1), reached for n = 2*MAX_TERMS - 1.
    localparam int M_MAX = (2 * MAX_TERMS - 1) * (2 * MAX_TERMS - 2);
    localparam int M_W   = $clog2(M_MAX + 1);

    // Field widths.
    localparam int ANG_W  = 32;
    localparam int TOL_W  = 31;
    localparam int SINE_W = 32;

    // Internal widths: reduced magnitude, x^2, term magnitude, product, sum.
    localparam int RED_W  = 41;
    localparam int AX_W   = 31;
    localparam int X2_W   = 33;
    localparam int TMAG_W = 32;
    localparam int PROD_W = TMAG_W + X2_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int SUM_W  = 36;

    // Divider: a 40-bit dividend retired eight quotient bits per cycle.
    localparam int DIV_W      = 40;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CHUNKS = DIV_W / DIV_STEPS;
    localparam int CHUNK_W    = $clog2(DIV_CHUNKS);

    // Range reduction walks 2*pi shifted left by this much down to zero.
    localparam int RED_SHIFT_MAX = 8;
    localparam int RED_K_W       = 4;

    localparam logic [31:0] Q29_PI     = 32'd1686629713;
    localparam logic [31:0] Q29_TWO_PI = 32'd3373259426;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd1074;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_REDUCE = 11'b000_0000_0010,
        ST_FOLD   = 11'b000_0000_0100,
        ST_SQUARE = 11'b000_0000_1000,
        ST_X2     = 11'b000_0001_0000,
        ST_TEST   = 11'b000_0010_0000,
        ST_MUL    = 11'b000_0100_0000,
        ST_RND    = 11'b000_1000_0000,
        ST_DIV    = 11'b001_0000_0000,
        ST_ACC    = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } state_t;

endpackage

`default_nettype wire

// ----- design/sine_taylor_to_tolerance.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Width  Contents
// s_        in         32     tdata: angle, signed Q12.20 radians
// m_        out        40+1   tdata: sine Q3.29, terms_used; tuser: capped
// cfg_      in         31     tolerance, unsigned Q1.30
//
// An angle passes range reduction, the fold and the squaring, then one round of
// test, multiply, round, divide and accumulate per term; each term uses the shared
// multiplier and the divider that retires eight quotient bits per cycle.
// Reset (aresetn, synchronous, active low) empties the block and restores the
// tolerance to 1074. s_tready is high only while the sequencer is idle; a
// result that waits for m_tready does not stop the next angle from entering.
module sine_taylor_to_tolerance (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [stt_pkg::ANG_W-1:0]       s_tdata,   // [31:0] angle
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [39:0]                     m_tdata,   // [31:0] sine, [36:32] terms_used
    output logic [0:0]                      m_tuser,   // [0] capped
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [stt_pkg::TOL_W-1:0]       cfg_data   // [30:0] tolerance
);
    import stt_pkg::*;

    state_t state_reg, state_next;

    logic [TOL_W-1:0]   tol_reg, tol_next;
    logic [RED_W-1:0]   red_reg, red_next;
    logic [RED_K_W-1:0] red_k_reg, red_k_next;
    logic               neg_reg, neg_next;
    logic [AX_W-1:0]    ax_reg, ax_next;
    logic [X2_W-1:0]    x2_reg, x2_next;
    logic [TMAG_W-1:0]  tmag_reg, tmag_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [TERMS_W-1:0] terms_reg, terms_next;
    logic [M_W-1:0]     m_reg, m_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [M_W-1:0]     rem_reg, rem_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic               capped_reg, capped_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SINE_W-1:0]      out_sine_reg, out_sine_next;
    logic [TERMS_OUT_W-1:0] out_terms_reg, out_terms_next;
    logic                   out_capped_reg, out_capped_next;

    // Shared multiplier and its operand selection.
    logic [TMAG_W-1:0] mul_a;
    logic [X2_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p;

    logic [ANG_W:0]     ang_ext;
    logic [ANG_W:0]     ang_mag;
    logic [RED_W-1:0]   red_sub;
    logic [RND_W-1:0]   rnd_sum;
    logic [DIV_W-1:0]   div_q;
    logic [M_W-1:0]     div_rem;
    logic [TMAG_W:0]    tmag_x2;
    logic               tol_met;
    logic               accept;
    logic [SUM_W-1:0]   sum_init;
    logic [SINE_W-1:0]  sine_sat;
    logic [TERMS_OUT_W-1:0] terms_sat;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_terms_reg, out_sine_reg};
    assign m_tuser  = out_capped_reg;

    // The multiplier squares the reduced angle once, then forms |term| * x^2.
    always_comb begin
        if (state_reg == ST_SQUARE) begin
            mul_a = TMAG_W'(ax_reg);
            mul_b = X2_W'(ax_reg);
        end else begin
            mul_a = tmag_reg;
            mul_b = x2_reg;
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Round half up after the Q.29 rescale. For a series term the bias is
    // half of n*(n-1)*2^29, which lets the following divide be by n*(n-1).
    always_comb begin
        if (state_reg == ST_X2) begin
            rnd_sum = RND_W'(prod_reg) + (RND_W'(1) << 28);
        end else begin
            rnd_sum = RND_W'(prod_reg) + (RND_W'(m_reg) << 28);
        end
    end

    // Eight restoring steps of the quotient per cycle, remainder below m.
    always_comb begin
        logic [M_W:0] rem_w;
        div_q   = div_reg;
        div_rem = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            rem_w = {div_rem, div_q[DIV_W-1]};
            div_q = {div_q[DIV_W-2:0], 1'b0};
            if (rem_w >= {1'b0, m_reg}) begin
                rem_w    = rem_w - {1'b0, m_reg};
                div_q[0] = 1'b1;
            end
            div_rem = rem_w[M_W-1:0];
        end
    end

    assign ang_ext = {s_tdata[ANG_W-1], s_tdata};
    assign ang_mag = s_tdata[ANG_W-1] ? (~ang_ext + (ANG_W+1)'(1)) : ang_ext;
    assign red_sub = RED_W'(Q29_TWO_PI) << red_k_reg;

    // The series stops once the term magnitude is within tolerance (the Q.29 term is doubled to the Q.30 scale).
    assign tmag_x2 = {tmag_reg, 1'b0};
    assign tol_met = (tmag_x2 <= (TMAG_W+1)'(tol_reg));

    assign sum_init = neg_reg ? (SUM_W'(0) - SUM_W'(ax_reg)) : SUM_W'(ax_reg);

    // Clamp the accumulator and the term count to their output fields.
    always_comb begin
        if ($signed(sum_reg) > $signed(SUM_W'(32'h7FFF_FFFF))) begin
            sine_sat = 32'h7FFF_FFFF;
        end else if ($signed(sum_reg) < -$signed(SUM_W'(33'h0_8000_0000))) begin
            sine_sat = 32'h8000_0000;
        end else begin
            sine_sat = sum_reg[SINE_W-1:0];
        end
        if (terms_reg > TERMS_W'(TERMS_CAP)) begin
            terms_sat = TERMS_OUT_W'(TERMS_CAP);
        end else begin
            terms_sat = TERMS_OUT_W'(terms_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        tol_next        = tol_reg;
        red_next        = red_reg;
        red_k_next      = red_k_reg;
        neg_next        = neg_reg;
        ax_next         = ax_reg;
        x2_next         = x2_reg;
        tmag_next       = tmag_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        terms_next      = terms_reg;
        m_next          = m_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        capped_next     = capped_reg;
        out_valid_next  = out_valid_reg;
        out_sine_next   = out_sine_reg;
        out_terms_next  = out_terms_reg;
        out_capped_next = out_capped_reg;

        if (cfg_valid && cfg_ready) begin
            tol_next = cfg_data;
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // |angle| in Q.29; the sign is kept apart.
                    red_next   = {ang_mag[ANG_W-1:0], 9'b0};
                    neg_next   = s_tdata[ANG_W-1];
                    red_k_next = RED_K_W'(RED_SHIFT_MAX);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                // One quotient bit of the remainder by 2*pi per cycle.
                if (red_reg >= red_sub) begin
                    red_next = red_reg - red_sub;
                end
                red_k_next = red_k_reg - RED_K_W'(1);
                if (red_k_reg == '0) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                // Beyond pi in either direction the angle wraps by 2*pi,
                // which flips its sign and leaves 2*pi minus the magnitude.
                if (red_reg > RED_W'(Q29_PI)) begin
                    ax_next  = AX_W'(RED_W'(Q29_TWO_PI) - red_reg);
                    neg_next = !neg_reg;
                end else begin
                    ax_next = red_reg[AX_W-1:0];
                end
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                prod_next  = mul_p;
                state_next = ST_X2;
            end
            ST_X2: begin
                x2_next     = rnd_sum[X2_W+28:29];
                tmag_next   = TMAG_W'(ax_reg);
                sum_next    = sum_init;
                terms_next  = TERMS_W'(1);
                m_next      = '0;
                capped_next = 1'b0;
                state_next  = ST_TEST;
            end
            ST_TEST: begin
                if (tol_met) begin
                    state_next = ST_DONE;
                end else if (terms_reg >= TERMS_W'(MAX_TERMS)) begin
                    capped_next = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    // n steps by two: n*(n-1) grows by 8*terms - 2.
                    m_next     = m_reg + (M_W'(terms_reg) << 3) - M_W'(2);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_RND;
            end
            ST_RND: begin
                div_next   = DIV_W'(rnd_sum[RND_W-1:29]);
                rem_next   = '0;
                chunk_next = CHUNK_W'(DIV_CHUNKS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                div_next   = div_q;
                rem_next   = div_rem;
                chunk_next = chunk_reg - CHUNK_W'(1);
                if (chunk_reg == '0) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                tmag_next  = div_reg[TMAG_W-1:0];
                neg_next   = !neg_reg;
                if (!neg_reg) begin
                    sum_next = sum_reg - SUM_W'(div_reg[TMAG_W-1:0]);
                end else begin
                    sum_next = sum_reg + SUM_W'(div_reg[TMAG_W-1:0]);
                end
                terms_next = terms_reg + TERMS_W'(1);
                state_next = ST_TEST;
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_sine_next   = sine_sat;
                    out_terms_next  = terms_sat;
                    out_capped_next = capped_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_reg        <= red_next;
        red_k_reg      <= red_k_next;
        neg_reg        <= neg_next;
        ax_reg         <= ax_next;
        x2_reg         <= x2_next;
        tmag_reg       <= tmag_next;
        prod_reg       <= prod_next;
        sum_reg        <= sum_next;
        terms_reg      <= terms_next;
        m_reg          <= m_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        chunk_reg      <= chunk_next;
        capped_reg     <= capped_next;
        out_sine_reg   <= out_sine_next;
        out_terms_reg  <= out_terms_next;
        out_capped_reg <= out_capped_next;
    end

`ifndef SYNTHESIS
    // An accepted angle keeps the input closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input stayed open after an angle was accepted");

    // The folded angle never exceeds pi when it reaches the multiplier.
    a_reduced_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQUARE) |-> (ax_reg <= AX_W'(Q29_PI)))
        else $error("reduced angle outside [-pi, pi]");

    // A capped result always reports the full term count.
    a_capped_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (out_terms_reg == TERMS_OUT_W'(TERMS_CAP)))
        else $error("capped result with a short term count");

    // A new result word appears only when the sequencer finishes an angle.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done step");
`endif

endmodule

`default_nettype wire
